### rtl/tsc_pkg.sv
// Shared constants, codes and types of the TDC subevent checker.
package tsc_pkg;

    localparam int MAX_WORDS = 16384;
    localparam int POS_W     = $clog2(MAX_WORDS);
    localparam int CHAN_W    = 10;
    localparam int NCHAN     = 1 << CHAN_W;
    localparam int EPOCH_W   = 10;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [POS_W-1:0]   LAST_POS  = POS_W'(MAX_WORDS - 1);
    localparam logic [15:0]        OVF_VALUE = 16'h7fff;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;
    localparam logic [CHAN_W-1:0]  CHAN_MAX  = '1;

    localparam logic [2:0] ST_HEADER   = 3'd0;
    localparam logic [2:0] ST_ACCEPTED = 3'd1;
    localparam logic [2:0] ST_ERRBITS  = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_DOUBLE   = 3'd4;
    localparam logic [2:0] ST_INVERT   = 3'd5;

    localparam logic [2:0] VD_CLEAN     = 3'd0;
    localparam logic [2:0] VD_DATA_ERR  = 3'd1;
    localparam logic [2:0] VD_BAD_COUNT = 3'd2;
    localparam logic [2:0] VD_NO_HEADER = 3'd3;
    localparam logic [2:0] VD_BAD_LEN   = 3'd4;

    typedef struct packed {
        logic [31:0]      word;
        logic             last;
        logic [POS_W-1:0] pos;
        logic             overrun;
    } t_item;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic               seen;
        logic               pend;
        logic [15:0]        last_value;
        logic [POS_W-1:0]   ovf_pos;
        logic [POS_W-1:0]   last_pos;
    } t_entry;

endpackage

### rtl/tdc_subevent_checker_unit.sv
// Path: an accepted beat passes the queue, the stage register and the output register.
// Throughput: one beat per cycle, set by the single per-channel read-modify-write port,
// unless the output is held or a clearing pass runs. Reset: synchronous, active low;
// clears control state and starts a clearing pass over all 1024 channel entries,
// repeated every 1024 subevents, during which beats queue but are not processed.
// Top level of the TDC subevent checker.
module tdc_subevent_checker_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [31:0]        i_data_word,
    input  logic               i_last_word,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_word_status,
    output logic [9:0]         o_channel,
    output logic signed [15:0] o_time_value,
    output logic               o_subevent_done,
    output logic [2:0]         o_verdict,
    output logic [13:0]        o_first_error_position,
    output logic [31:0]        o_bad_subevent_count
);

    logic           push, full, pop, empty;
    tsc_pkg::t_item f_item, q_item;

    tsc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data_word (i_data_word),
        .i_last_word (i_last_word),
        .i_full      (full),
        .o_push      (push),
        .o_item      (f_item)
    );

    tsc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_empty (empty)
    );

    tsc_back u_back (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_empty                (empty),
        .i_item                 (q_item),
        .o_pop                  (pop),
        .o_valid                (o_valid),
        .i_ready                (i_ready),
        .o_word_status          (o_word_status),
        .o_channel              (o_channel),
        .o_time_value           (o_time_value),
        .o_subevent_done        (o_subevent_done),
        .o_verdict              (o_verdict),
        .o_first_error_position (o_first_error_position),
        .o_bad_subevent_count   (o_bad_subevent_count)
    );

endmodule

### rtl/tsc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module tsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/tsc_front.sv
// Front end: accepts input beats, tracks word position and overrun.
module tsc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [31:0]          i_data_word,
    input  logic                 i_last_word,
    input  logic                 i_full,
    output logic                 o_push,
    output tsc_pkg::t_item       o_item
);

    logic [tsc_pkg::POS_W-1:0] r_pos, n_pos;
    logic                      r_ovr, n_ovr;
    logic                      cur_ovr;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign cur_ovr = (r_pos == '0) ? 1'b0 : r_ovr;

    always_comb begin
        o_item.word    = i_data_word;
        o_item.last    = i_last_word;
        o_item.pos     = r_pos;
        o_item.overrun = cur_ovr;
        n_pos = r_pos;
        n_ovr = r_ovr;
        if (o_push) begin
            n_ovr = cur_ovr;
            if (i_last_word) begin
                n_pos = '0;
            end else if (r_pos != tsc_pkg::LAST_POS) begin
                n_pos = r_pos + 1'b1;
            end else begin
                n_ovr = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_ovr <= 1'b0;
        end else begin
            r_pos <= n_pos;
            r_ovr <= n_ovr;
        end
    end

endmodule

### rtl/tsc_fifo.sv
// Short queue of position-tagged beats between the front end and the back end.
module tsc_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tsc_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output tsc_pkg::t_item o_item,
    output logic           o_empty
);

    tsc_pkg::t_item                  r_mem [tsc_pkg::FIFO_DEPTH];
    logic [tsc_pkg::FIFO_AW-1:0]     r_wptr, r_rptr;
    logic [tsc_pkg::FIFO_AW:0]       r_count;

    assign o_full  = (r_count == (tsc_pkg::FIFO_AW+1)'(tsc_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + (tsc_pkg::FIFO_AW+1)'(i_push)
                       - (tsc_pkg::FIFO_AW+1)'(i_pop);
        end
    end

endmodule

### rtl/tsc_back.sv
// Back end: per-channel read-modify-write, subevent verdict and output register.
module tsc_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    input  tsc_pkg::t_item              i_item,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [2:0]                  o_word_status,
    output logic [9:0]                  o_channel,
    output logic signed [15:0]          o_time_value,
    output logic                        o_subevent_done,
    output logic [2:0]                  o_verdict,
    output logic [13:0]                 o_first_error_position,
    output logic [31:0]                 o_bad_subevent_count
);

    localparam int EW = $bits(tsc_pkg::t_entry);

    tsc_pkg::t_item             r_e;
    logic                       r_e_vld;
    logic                       r_clr;
    logic [tsc_pkg::CHAN_W-1:0] r_clr_addr;
    logic [tsc_pkg::EPOCH_W-1:0] r_epoch;
    logic                       r_byp_vld;
    logic [tsc_pkg::CHAN_W-1:0] r_byp_chan;
    tsc_pkg::t_entry            r_byp_ent;

    logic [31:0]                r_hcount, n_hcount;
    logic [31:0]                r_hflag, n_hflag;
    logic                       r_derr, n_derr;
    logic [tsc_pkg::POS_W-1:0]  r_dpos, n_dpos;
    logic                       r_inv, n_inv;
    logic [tsc_pkg::CHAN_W-1:0] r_ichan, n_ichan;
    logic [tsc_pkg::POS_W-1:0]  r_ipos, n_ipos;
    logic [31:0]                r_bad, n_bad;

    logic                       e_fire, wrap, ent_we;
    logic [EW-1:0]              rdata;
    tsc_pkg::t_entry            ent, wr_ent;
    logic [tsc_pkg::CHAN_W-1:0] chan;
    logic [5:0]                 errs;
    logic [15:0]                raw;
    logic                       is_hdr, seen_v, pend_v;
    logic [2:0]                 status, verdict;
    logic [tsc_pkg::POS_W-1:0]  errpos;
    logic                       ram_we;
    logic [tsc_pkg::CHAN_W-1:0] ram_waddr;
    tsc_pkg::t_entry            ram_wdata;

    assign e_fire = r_e_vld && (!o_valid || i_ready);
    assign wrap   = r_e.last && (r_epoch == tsc_pkg::EPOCH_MAX);
    assign o_pop  = !i_empty && !r_clr && !(r_e_vld && wrap) && (!r_e_vld || e_fire);

    assign ram_we    = r_clr || (e_fire && ent_we);
    assign ram_waddr = r_clr ? r_clr_addr : chan;
    assign ram_wdata = r_clr ? tsc_pkg::t_entry'('0) : wr_ent;

    tsc_ram #(
        .WIDTH (EW),
        .DEPTH (tsc_pkg::NCHAN)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (o_pop),
        .i_raddr (i_item.word[31:22]),
        .o_rdata (rdata)
    );

    always_comb begin
        chan   = r_e.word[31:22];
        errs   = r_e.word[21:16];
        raw    = r_e.word[15:0];
        is_hdr = (r_e.pos < tsc_pkg::POS_W'(4));
        ent    = (r_byp_vld && r_byp_chan == chan) ? r_byp_ent : tsc_pkg::t_entry'(rdata);
        seen_v = (ent.epoch == r_epoch) && ent.seen;
        pend_v = (ent.epoch == r_epoch) && ent.pend;

        if (r_e.pos == '0) begin
            n_hcount = '0;
            n_hflag  = '0;
            n_derr   = 1'b0;
            n_dpos   = '0;
            n_inv    = 1'b0;
            n_ichan  = '0;
            n_ipos   = '0;
        end else begin
            n_hcount = r_hcount;
            n_hflag  = r_hflag;
            n_derr   = r_derr;
            n_dpos   = r_dpos;
            n_inv    = r_inv;
            n_ichan  = r_ichan;
            n_ipos   = r_ipos;
        end
        n_bad  = r_bad;
        status = tsc_pkg::ST_HEADER;
        ent_we = 1'b0;
        wr_ent = ent;
        wr_ent.epoch = r_epoch;
        wr_ent.seen  = seen_v;
        wr_ent.pend  = pend_v;

        if (is_hdr) begin
            if (r_e.pos == '0) begin
                n_hcount = r_e.word;
            end else if (r_e.pos == tsc_pkg::POS_W'(1)) begin
                n_hflag = r_e.word;
            end
        end else if (errs != '0) begin
            status = tsc_pkg::ST_ERRBITS;
            if (!n_derr) begin
                n_derr = 1'b1;
                n_dpos = r_e.pos;
            end
        end else if (raw == tsc_pkg::OVF_VALUE) begin
            ent_we         = 1'b1;
            wr_ent.pend    = 1'b1;
            wr_ent.ovf_pos = r_e.pos;
            if (pend_v) begin
                status = tsc_pkg::ST_DOUBLE;
                if (!n_derr) begin
                    n_derr = 1'b1;
                    n_dpos = ent.ovf_pos;
                end
            end else begin
                status = tsc_pkg::ST_OVERFLOW;
            end
        end else begin
            ent_we            = 1'b1;
            status            = tsc_pkg::ST_ACCEPTED;
            wr_ent.seen       = 1'b1;
            wr_ent.pend       = 1'b0;
            wr_ent.last_value = raw;
            wr_ent.last_pos   = r_e.pos;
            if (seen_v && ($signed(ent.last_value) <= $signed(raw))) begin
                status = tsc_pkg::ST_INVERT;
                if (!n_inv || chan < n_ichan) begin
                    n_inv   = 1'b1;
                    n_ichan = chan;
                    n_ipos  = ent.last_pos;
                end
            end
        end

        verdict = tsc_pkg::VD_CLEAN;
        errpos  = '0;
        if (r_e.last) begin
            priority if (r_e.overrun || n_hcount != 32'(r_e.pos)) begin
                verdict = tsc_pkg::VD_BAD_COUNT;
            end else if (!n_hflag[31]) begin
                verdict = tsc_pkg::VD_NO_HEADER;
            end else if (n_hflag[15:0] != 16'({r_e.pos, 2'b00})) begin
                verdict = tsc_pkg::VD_BAD_LEN;
            end else if (n_derr || n_inv) begin
                verdict = tsc_pkg::VD_DATA_ERR;
                errpos  = n_derr ? n_dpos : n_ipos;
                if (r_bad != '1) begin
                    n_bad = r_bad + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_e <= i_item;
        end
        if (e_fire) begin
            o_word_status          <= status;
            o_channel              <= is_hdr ? '0 : chan;
            o_time_value           <= is_hdr ? '0 : $signed(raw);
            o_subevent_done        <= r_e.last;
            o_verdict              <= verdict;
            o_first_error_position <= errpos;
            o_bad_subevent_count   <= n_bad;
        end
        if (e_fire && ent_we) begin
            r_byp_chan <= chan;
            r_byp_ent  <= wr_ent;
        end
        if (!i_rst_n) begin
            r_e_vld    <= 1'b0;
            o_valid    <= 1'b0;
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_epoch    <= '0;
            r_byp_vld  <= 1'b0;
            r_hcount   <= '0;
            r_hflag    <= '0;
            r_derr     <= 1'b0;
            r_dpos     <= '0;
            r_inv      <= 1'b0;
            r_ichan    <= '0;
            r_ipos     <= '0;
            r_bad      <= '0;
        end else begin
            if (o_pop) begin
                r_e_vld <= 1'b1;
            end else if (e_fire) begin
                r_e_vld <= 1'b0;
            end
            if (e_fire) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == tsc_pkg::CHAN_MAX) begin
                    r_clr <= 1'b0;
                end
            end
            if (e_fire && ent_we && !wrap) begin
                r_byp_vld <= 1'b1;
            end
            if (e_fire) begin
                r_hcount <= n_hcount;
                r_hflag  <= n_hflag;
                r_derr   <= n_derr;
                r_dpos   <= n_dpos;
                r_inv    <= n_inv;
                r_ichan  <= n_ichan;
                r_ipos   <= n_ipos;
                r_bad    <= n_bad;
                if (r_e.last) begin
                    r_epoch <= r_epoch + 1'b1;
                    if (wrap) begin
                        r_clr      <= 1'b1;
                        r_clr_addr <= '0;
                        r_byp_vld  <= 1'b0;
                    end
                end
            end
        end
    end

    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !r_clr)
        else $error("Queue popped during the clearing pass.");

    a_wrap_starts_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (e_fire && wrap) |=> r_clr)
        else $error("Epoch wrap did not start a clearing pass.");

    a_verdict_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_verdict != tsc_pkg::VD_CLEAN) |-> o_subevent_done)
        else $error("Verdict reported on a beat that does not end a subevent.");

    a_bad_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_bad >= $past(r_bad)))
        else $error("Bad subevent count decreased.");

endmodule
